// ----- rtl/lif_neuron_spike_integrator_core_assert.svh -----
// Assertion macros shared by the neuron core modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef LIF_NEURON_SPIKE_INTEGRATOR_CORE_ASSERT_SVH
`define LIF_NEURON_SPIKE_INTEGRATOR_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define LIF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lif core assertion failed");
// Next-cycle implication, checked outside reset.
`define LIF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lif core assertion failed");
`else
`define LIF_ASSERT_IMP(label, ante, cons)
`define LIF_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- rtl/lif_pkg.sv -----
// Package for the leaky integrate-and-fire neuron core.
// Holds item types, register codes, fixed-point constants and the table builder.
// No dependencies.
package lif_pkg;

  // Input item: one spike.
  typedef struct packed {
    logic [31:0]        spike_time;
    logic signed [23:0] spike_weight;
  } spike_t;

  // Result item for one spike.
  typedef struct packed {
    logic               fired;
    logic [1:0]         status;
    logic signed [31:0] membrane_after;
  } result_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_INVERSE_TAU      = 2'd0;
  localparam logic [1:0] CFG_FIRE_THRESHOLD   = 2'd1;
  localparam logic [1:0] CFG_REFRACTORY_TICKS = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_REFRACTORY = 2'd1;
  localparam logic [1:0] ST_BACKWARD   = 2'd2;

  // Register reset values.
  localparam logic [23:0]        INVERSE_TAU_RST      = 24'd838861;
  localparam logic signed [31:0] FIRE_THRESHOLD_RST   = 32'sd65536;
  localparam logic [15:0]        REFRACTORY_TICKS_RST = 16'd80;

  // Fixed-point constants.
  localparam logic [63:0] LOG2E_Q30  = 64'd1549082005;
  localparam logic [63:0] LN2_Q30    = 64'd744261118;
  localparam logic [63:0] ONE_Q30    = 64'd1073741824;
  localparam int          FRAC_BITS  = 28;
  // Exponent at or above 23 ms-units decays the membrane to zero.
  localparam logic [55:0] P_LIMIT    = 56'd6174015488;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [23:0]        inverse_tau;
    logic signed [31:0] fire_threshold;
    logic [15:0]        refractory_ticks;
  } cfg_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic check;
    logic logstep;
    logic lookup;
    logic mult;
    logic finish;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic skip;
    logic out_free;
  } sts_t;

  // Alternating Taylor series of exp(-t) in Q2.30, t in Q30.
  // Used only to build the constant decay table at elaboration.
  function automatic logic [31:0] exp_series(input logic [63:0] t);
    logic [63:0]        term;
    logic signed [63:0] sum;
    term = ONE_Q30;
    sum  = $signed(ONE_Q30);
    for (int k = 1; k <= 40; k++) begin
      term = ((term * t) >> 30) / 64'(k);
      if (k[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    return sum[31:0];
  endfunction

endpackage

// ----- rtl/lif_cfg.sv -----
// Configuration register file of the neuron core.
// Depends on lif_pkg for the register codes, reset values and cfg_t.
module lif_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output lif_pkg::cfg_t cfg
);

  // Writes are taken whenever the core is out of reset.
  assign cfg_ready = !rst;

  // Register writes by index; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inverse_tau      <= lif_pkg::INVERSE_TAU_RST;
      cfg.fire_threshold   <= lif_pkg::FIRE_THRESHOLD_RST;
      cfg.refractory_ticks <= lif_pkg::REFRACTORY_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lif_pkg::CFG_INVERSE_TAU:      cfg.inverse_tau      <= cfg_data[23:0];
        lif_pkg::CFG_FIRE_THRESHOLD:   cfg.fire_threshold   <= $signed(cfg_data);
        lif_pkg::CFG_REFRACTORY_TICKS: cfg.refractory_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/lif_ctrl.sv -----
// Sequencer of the neuron core: steps one spike item through the datapath.
// Depends on lif_pkg for cmd_t and sts_t, and on the assertion header.
`include "lif_neuron_spike_integrator_core_assert.svh"
module lif_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          spike_valid,
  output logic          spike_ready,
  input  lif_pkg::sts_t sts,
  output lif_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_LOG   = 3'd2;
  localparam logic [2:0] S_ROM   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // A spike item is taken only when idle and out of reset.
  assign spike_ready = (state == S_IDLE) && !rst;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (spike_valid && spike_ready) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.skip ? S_FIN : S_LOG;
      end
      S_LOG: begin
        cmd.logstep = 1'b1;
        state_next  = S_ROM;
      end
      S_ROM: begin
        cmd.lookup = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mult   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `LIF_ASSERT_NXT(a_load_to_check, cmd.load, state == S_CHECK)
  `LIF_ASSERT_NXT(a_fin_waits, state == S_FIN && !sts.out_free, state == S_FIN)
  `LIF_ASSERT_IMP(a_finish_free, cmd.finish, sts.out_free && state == S_FIN)

endmodule

// ----- rtl/lif_dpath.sv -----
// Datapath of the neuron core: neuron state, decay arithmetic, result register.
// Depends on lif_pkg and on the assertion header.
`include "lif_neuron_spike_integrator_core_assert.svh"
module lif_dpath #(
  parameter int EXP_TABLE_ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  lif_pkg::cmd_t    cmd,
  output lif_pkg::sts_t    sts,
  input  lif_pkg::spike_t  spike,
  input  lif_pkg::cfg_t    cfg,
  output logic             result_valid,
  input  logic             result_ready,
  output lif_pkg::result_t result
);

  localparam int IDX_W      = $clog2(EXP_TABLE_ENTRIES);
  localparam int IDX_PROD_W = lif_pkg::FRAC_BITS + IDX_W + 1;
  localparam logic signed [33:0] SUM_MAX = 34'sd2147483647;
  localparam logic signed [33:0] SUM_MIN = -34'sd2147483648;

  // Neuron state.
  logic signed [31:0] membrane;
  logic [31:0]        last_update_time;
  logic [31:0]        last_fire_time;
  logic               has_fired;

  // Working registers of one item.
  logic [31:0]        spk_time;
  logic signed [23:0] spk_weight;
  logic [1:0]         status_q;
  logic               big_q;
  logic [32:0]        p_q;
  logic [33:0]        y_q;
  logic               zero_q;
  logic [4:0]         shift_q;
  logic [31:0]        rom_q;
  logic [31:0]        mag_q;
  logic               neg_q;
  logic [31:0]        scaled_q;

  // Decay table 2^(-i/N) in Q2.30, built at elaboration.
  logic [31:0] exp_rom [EXP_TABLE_ENTRIES];
  for (genvar I = 0; I < EXP_TABLE_ENTRIES; I++) begin : g_rom
    localparam logic [63:0] TV = (64'(I) * lif_pkg::LN2_Q30) / EXP_TABLE_ENTRIES;
    assign exp_rom[I] = lif_pkg::exp_series(TV);
  end

  // Refractory and time-order tests, elapsed time and exponent product.
  logic signed [33:0] fire_diff;
  logic               refr;
  logic               backw;
  logic [31:0]        dt;
  logic [55:0]        p_full;
  assign fire_diff = $signed({2'b00, spk_time}) - $signed({2'b00, last_fire_time});
  assign refr      = has_fired && (fire_diff < $signed({18'd0, cfg.refractory_ticks}));
  assign backw     = spk_time < last_update_time;
  assign dt        = spk_time - last_update_time;
  assign p_full    = 56'(dt) * 56'(cfg.inverse_tau);

  assign sts.skip     = refr || backw;
  assign sts.out_free = !result_valid || result_ready;

  // Exponent converted to log2 units.
  logic [63:0] y_full;
  assign y_full = 64'(p_q) * lif_pkg::LOG2E_Q30;

  // Table index from the fractional part.
  logic [IDX_PROD_W-1:0] idx_prod;
  logic [IDX_W-1:0]      idx;
  assign idx_prod = IDX_PROD_W'(y_q[27:0]) * IDX_PROD_W'(EXP_TABLE_ENTRIES);
  assign idx      = idx_prod[lif_pkg::FRAC_BITS +: IDX_W];

  // Magnitude times table value.
  logic [63:0] mprod;
  assign mprod = 64'(mag_q) * 64'(rom_q);

  // Shift, sign, weight add, saturation and threshold.
  logic [31:0]        shifted;
  logic signed [33:0] decayed;
  logic signed [33:0] sum;
  logic signed [31:0] sat;
  logic               fire_now;
  always_comb begin
    shifted = scaled_q >> shift_q;
    if (zero_q) begin
      decayed = '0;
    end else if (neg_q) begin
      decayed = -$signed({2'b00, shifted});
    end else begin
      decayed = $signed({2'b00, shifted});
    end
    sum = decayed + {{10{spk_weight[23]}}, spk_weight};
    if (sum > SUM_MAX) begin
      sat = SUM_MAX[31:0];
    end else if (sum < SUM_MIN) begin
      sat = SUM_MIN[31:0];
    end else begin
      sat = sum[31:0];
    end
    fire_now = (sat >= cfg.fire_threshold);
  end

  // Item working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      spk_time   <= spike.spike_time;
      spk_weight <= spike.spike_weight;
    end
    if (cmd.check) begin
      status_q <= refr ? lif_pkg::ST_REFRACTORY :
                  (backw ? lif_pkg::ST_BACKWARD : lif_pkg::ST_OK);
      big_q    <= p_full >= lif_pkg::P_LIMIT;
      p_q      <= p_full[32:0];
    end
    if (cmd.logstep) begin
      y_q <= y_full[63:30];
    end
    if (cmd.lookup) begin
      zero_q  <= big_q || y_q[33];
      shift_q <= y_q[32:28];
      rom_q   <= exp_rom[idx];
      neg_q   <= membrane[31];
      mag_q   <= membrane[31] ? 32'(-membrane) : 32'(membrane);
    end
    if (cmd.mult) begin
      scaled_q <= mprod[61:30];
    end
  end

  // Neuron state update at the end of an integrated item.
  always_ff @(posedge clk) begin
    if (rst) begin
      membrane         <= '0;
      last_update_time <= '0;
      last_fire_time   <= '0;
      has_fired        <= 1'b0;
    end else if (cmd.finish && status_q == lif_pkg::ST_OK) begin
      last_update_time <= spk_time;
      membrane         <= fire_now ? 32'sd0 : sat;
      if (fire_now) begin
        last_fire_time <= spk_time;
        has_fired      <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.status <= status_q;
      if (status_q == lif_pkg::ST_OK) begin
        result.fired          <= fire_now;
        result.membrane_after <= fire_now ? 32'sd0 : sat;
      end else begin
        result.fired          <= 1'b0;
        result.membrane_after <= membrane;
      end
    end
  end

  `LIF_ASSERT_IMP(a_fire_clears, result_valid && result.fired,
    result.status == lif_pkg::ST_OK && result.membrane_after == 32'sd0)
  `LIF_ASSERT_NXT(a_fire_marks,
    cmd.finish && status_q == lif_pkg::ST_OK && fire_now,
    has_fired && last_fire_time == $past(spk_time))
  `LIF_ASSERT_NXT(a_skip_keeps,
    cmd.finish && status_q != lif_pkg::ST_OK,
    membrane == $past(membrane))

endmodule

// ----- rtl/lif_neuron_spike_integrator_core.sv -----
// Leaky integrate-and-fire neuron core, one spike item at a time.
// An integrated spike steps through the sequencer states CHECK (dt*tau multiply), LOG (log2
// multiply), ROM (table read), MUL (membrane multiply) and FIN; a refractory or time-error
// spike goes from CHECK straight to FIN. FIN waits while a result is still held downstream,
// then result_valid is registered. A new spike is taken only once the last item is done.
// Reset (rst, synchronous): membrane and times cleared, never fired, registers at defaults.
module lif_neuron_spike_integrator_core #(
  parameter int EXP_TABLE_ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             spike_valid,
  output logic             spike_ready,
  input  lif_pkg::spike_t  spike,
  output logic             result_valid,
  input  logic             result_ready,
  output lif_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  lif_pkg::cfg_t cfg;
  lif_pkg::cmd_t cmd;
  lif_pkg::sts_t sts;

  lif_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lif_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .spike_valid (spike_valid),
    .spike_ready (spike_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  lif_dpath #(
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .spike        (spike),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
